// ===== src/fkl_pkg.sv =====
// fkl_pkg: shared types and constants for the face key lookup block
// transfer payload structs, key bundle, token passed between cells
// no dependencies
`timescale 1ns / 1ps

package fkl_pkg;

    // default sizes for the top level parameters
    localparam int DEF_TABLE_DEPTH = 256;
    localparam int DEF_MAX_NODES   = 4;

    // key fields carried by one input transfer
    localparam int KEY_FIELDS = 4;

    // field widths
    localparam int NODE_W  = 31;
    localparam int SUM_W   = 33;
    localparam int SLOT_W  = 8;
    localparam int LIMIT_W = 9;
    localparam int NPF_W   = 3;

    // nodes_per_face after reset
    localparam logic [NPF_W-1:0] NPF_RESET = 3'd4;

    // function codes
    localparam logic FUNC_STORE  = 1'b0;
    localparam logic FUNC_SEARCH = 1'b1;

    // one input transfer
    typedef struct packed {
        logic                func;
        logic [SLOT_W-1:0]   slot_index;
        logic [NODE_W-1:0]   key_node_0;
        logic [NODE_W-1:0]   key_node_1;
        logic [NODE_W-1:0]   key_node_2;
        logic [NODE_W-1:0]   key_node_3;
        logic [SUM_W-1:0]    key_sum;
        logic [LIMIT_W-1:0]  entries_in_use;
    } req_t;

    // one result transfer
    typedef struct packed {
        logic                found;
        logic [SLOT_W-1:0]   match_index;
    } rsp_t;

    // key as seen by the cells
    typedef struct packed {
        logic [KEY_FIELDS-1:0][NODE_W-1:0] node;
        logic [SUM_W-1:0]                  sum;
    } key_t;

    // search token handed from cell to cell
    typedef struct packed {
        logic              active;
        logic              found;
        logic [SLOT_W-1:0] idx;
    } token_t;

endpackage

// ===== src/fkl_cell.sv =====
// fkl_cell: one table slot of the lookup chain
// holds one stored key, compares it with the search key as the token passes
// depends on fkl_pkg
`timescale 1ns / 1ps

module fkl_cell #(
    parameter int SLOT_ID   = 0,
    parameter int CMP_NODES = fkl_pkg::KEY_FIELDS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic                          wr_en,
    input  logic [fkl_pkg::SLOT_W-1:0]    wr_slot,
    input  fkl_pkg::key_t                 wr_key,
    input  fkl_pkg::key_t                 key,
    input  logic [fkl_pkg::NPF_W-1:0]     count,
    input  logic [fkl_pkg::LIMIT_W-1:0]   limit,
    input  fkl_pkg::token_t               tok_in,
    output fkl_pkg::token_t               tok_out
);

    // stored key
    logic [CMP_NODES-1:0][fkl_pkg::NODE_W-1:0] node_reg;
    logic [fkl_pkg::SUM_W-1:0]                 sum_reg;

    // token register toward the next cell
    fkl_pkg::token_t tok_reg;
    fkl_pkg::token_t tok_next;

    logic hit;
    logic in_range;

    // slot write on a store transfer
    always_ff @(posedge clk)
    begin
        if (wr_en && (32'(wr_slot) == 32'(SLOT_ID)))
        begin
            for (int n = 0; n < CMP_NODES; n++)
            begin
                node_reg[n] <= wr_key.node[n];
            end
            sum_reg <= wr_key.sum;
        end
    end

    // compare sum and the leading node ids, for a slot below the limit
    always_comb
    begin
        in_range = (32'(SLOT_ID) < 32'(limit));
        hit      = in_range && (sum_reg == key.sum);
        for (int n = 0; n < CMP_NODES; n++)
        begin
            if ((n < int'(count)) && (node_reg[n] != key.node[n]))
            begin
                hit = 1'b0;
            end
        end
    end

    // later slots override earlier hits
    always_comb
    begin
        tok_next = tok_in;
        if (tok_in.active && hit)
        begin
            tok_next.found = 1'b1;
            tok_next.idx   = fkl_pkg::SLOT_W'(SLOT_ID);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else if (adv)
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

// ===== src/face_key_lookup_top.sv =====
// face_key_lookup_top: table of face keys searched for the highest matching slot
// a row of fkl_cell slots, a search token walks the row one cell per cycle while the row advances
// depends on fkl_pkg and fkl_cell
`timescale 1ns / 1ps
//
// channel   direction  signals                          payload
// req       in         req_valid, req_ready, req_data   fkl_pkg::req_t
// rsp       out        rsp_valid, rsp_ready, rsp_data   fkl_pkg::rsp_t
// cfg       in         cfg_wen, cfg_wdata               nodes_per_face
//
// a store writes its slot on the transfer and the next request may follow at once
// a search result is registered once the token has passed the whole row: the token enters
// the row in the cycle after the transfer and moves one cell per cycle while the row advances
// one search at a time; req_ready is low from the search transfer until its result is registered
// a result held on rsp stalls the row only when the next search reaches its end
// reset clears control state and sets nodes_per_face to 4; slots hold no reset value

module face_key_lookup_top #(
    parameter int TABLE_DEPTH = fkl_pkg::DEF_TABLE_DEPTH,
    parameter int MAX_NODES   = fkl_pkg::DEF_MAX_NODES
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_ready,
    input  fkl_pkg::req_t               req_data,
    output logic                        rsp_valid,
    input  logic                        rsp_ready,
    output fkl_pkg::rsp_t               rsp_data,
    input  logic                        cfg_wen,
    input  logic [fkl_pkg::NPF_W-1:0]   cfg_wdata
);

    localparam int CMP_NODES =
        (MAX_NODES < fkl_pkg::KEY_FIELDS) ? MAX_NODES : fkl_pkg::KEY_FIELDS;

    // control and held search context
    logic                          busy_reg, busy_next;
    logic                          start_reg;
    logic                          rsp_valid_reg, rsp_valid_next;
    fkl_pkg::rsp_t                 rsp_data_reg;
    logic [fkl_pkg::NPF_W-1:0]     npf_reg;
    fkl_pkg::key_t                 key_reg;
    logic [fkl_pkg::NPF_W-1:0]     count_reg;
    logic [fkl_pkg::LIMIT_W-1:0]   limit_reg;

    logic          accept;
    logic          store_en;
    logic          search_start;
    logic          adv;
    logic          done;
    fkl_pkg::key_t req_key;

    fkl_pkg::token_t tok [TABLE_DEPTH+1];

    // handshake decode
    assign req_ready    = !busy_reg;
    assign accept       = req_valid && req_ready;
    assign store_en     = accept && (req_data.func == fkl_pkg::FUNC_STORE);
    assign search_start = accept && (req_data.func == fkl_pkg::FUNC_SEARCH);

    // row advances unless the finished token cannot leave
    assign adv  = !(tok[TABLE_DEPTH].active && rsp_valid_reg && !rsp_ready);
    assign done = adv && tok[TABLE_DEPTH].active;

    // key bundle from the request fields
    always_comb
    begin
        req_key.node[0] = req_data.key_node_0;
        req_key.node[1] = req_data.key_node_1;
        req_key.node[2] = req_data.key_node_2;
        req_key.node[3] = req_data.key_node_3;
        req_key.sum     = req_data.key_sum;
    end

    // nodes_per_face register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            npf_reg <= fkl_pkg::NPF_RESET;
        end
        else if (cfg_wen)
        begin
            npf_reg <= cfg_wdata;
        end
    end

    // search context captured at the request transfer
    always_ff @(posedge clk)
    begin
        if (search_start)
        begin
            key_reg   <= req_key;
            limit_reg <= req_data.entries_in_use;
            count_reg <= (32'(npf_reg) > 32'(CMP_NODES)) ?
                         fkl_pkg::NPF_W'(CMP_NODES) : npf_reg;
        end
    end

    // busy and result valid
    always_comb
    begin
        busy_next      = busy_reg;
        rsp_valid_next = rsp_valid_reg;
        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        if (done)
        begin
            busy_next      = 1'b0;
            rsp_valid_next = 1'b1;
        end
        if (search_start)
        begin
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            start_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            start_reg     <= search_start;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (done)
        begin
            rsp_data_reg.found       <= tok[TABLE_DEPTH].found;
            rsp_data_reg.match_index <= tok[TABLE_DEPTH].idx;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    // token entering the first cell
    always_comb
    begin
        tok[0].active = start_reg;
        tok[0].found  = 1'b0;
        tok[0].idx    = '0;
    end

    // row of slot cells
    for (genvar k = 0; k < TABLE_DEPTH; k++)
    begin : g_cell
        fkl_cell #(
            .SLOT_ID   (k),
            .CMP_NODES (CMP_NODES)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .adv     (adv),
            .wr_en   (store_en),
            .wr_slot (req_data.slot_index),
            .wr_key  (req_key),
            .key     (key_reg),
            .count   (count_reg),
            .limit   (limit_reg),
            .tok_in  (tok[k]),
            .tok_out (tok[k+1])
        );
    end

    // checks
    a_start_after_search: assert property (@(posedge clk) disable iff (!rst_n)
        search_start |=> start_reg)
        else $error("search transfer did not launch a token");

    a_start_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start_reg |-> busy_reg)
        else $error("token launched while not busy");

    a_no_token_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> !tok[TABLE_DEPTH].active)
        else $error("token at end of row while idle");

    a_miss_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && !rsp_data_reg.found) |-> (rsp_data_reg.match_index == '0))
        else $error("miss result carries a nonzero index");

endmodule
